>>> rtl/tfsc_pkg.sv
package tfsc_pkg;

    // Field widths.
    localparam int unsigned READING_W = 17;
    localparam int unsigned DEG_W     = 7;
    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned TRI_W     = 13;  // largest triangular number of a 7-bit count
    localparam int unsigned PROD_W    = TRI_W + SPEED_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned IN_TDATA_W = 24;

    // Divider constant for millidegrees to whole degrees.
    localparam int unsigned MILLI_PER_DEG = 1000;
    localparam int unsigned DEG_REM_W     = 10;   // remainder stays below 1000
    localparam int unsigned DEG_QUOT_W    = 8;    // 131071 / 1000 fits in 8 bits
    localparam logic [DEG_W-1:0] DEG_MAX  = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING  = 3'd4;

    // Register reset values.
    localparam logic [DEG_W-1:0]   RST_LOW_THRESHOLD  = 7'd63;
    localparam logic [DEG_W-1:0]   RST_RAMP_THRESHOLD = 7'd66;
    localparam logic [DEG_W-1:0]   RST_FULL_THRESHOLD = 7'd86;
    localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR    = 16'd500;
    localparam logic [SPEED_W-1:0] RST_SPEED_CEILING  = 16'd6500;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEG,
        ST_DECIDE,
        ST_RATIO,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RP_IDLE,
        RP_MUL,
        RP_BIAS,
        RP_DIV,
        RP_DONE
    } ratio_phase_t;

    typedef struct packed {
        logic                 start;
        logic [READING_W-1:0] dividend;
    } deg_req_t;

    typedef struct packed {
        logic             done;
        logic [DEG_W-1:0] degrees;
    } deg_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DEG_W-1:0]   num_n;
        logic [DEG_W-1:0]   den_n;
        logic [SPEED_W-1:0] span;
    } ratio_req_t;

    typedef struct packed {
        logic               done;
        logic [SPEED_W-1:0] quot;
    } ratio_rsp_t;

    // Triangular number n(n+1)/2 of a 7-bit count.
    function automatic logic [TRI_W-1:0] tri7(input logic [DEG_W-1:0] n);
        logic [TRI_W:0] prod;
        prod = 14'({7'd0, n}) * 14'({6'd0, {1'b0, n} + 8'd1});
        return prod[TRI_W:1];
    endfunction

endpackage

>>> rtl/tfsc_deg.sv
module tfsc_deg (
    input  logic               clk,
    input  logic               rst_n,
    input  tfsc_pkg::deg_req_t req,
    output tfsc_pkg::deg_rsp_t rsp
);
    import tfsc_pkg::*;

    // Restoring division by 1000, one dividend bit per cycle.
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [READING_W-1:0]  dvd_reg, dvd_next;
    logic [DEG_REM_W-1:0]  rem_reg, rem_next;
    logic [DEG_QUOT_W-1:0] quot_reg, quot_next;
    logic [DEG_REM_W:0]    rem_sh;
    logic                  ge;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[READING_W-1]};
        ge        = rem_sh >= (DEG_REM_W+1)'(MILLI_PER_DEG);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(READING_W - 1);
            dvd_next  = req.dividend;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[READING_W-2:0], 1'b0};
            rem_next  = ge ? DEG_REM_W'(rem_sh - (DEG_REM_W+1)'(MILLI_PER_DEG))
                           : rem_sh[DEG_REM_W-1:0];
            quot_next = {quot_reg[DEG_QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    // Readings above 127.999 degrees saturate.
    assign rsp.done    = done_reg;
    assign rsp.degrees = quot_reg[DEG_QUOT_W-1] ? DEG_MAX : quot_reg[DEG_W-1:0];

endmodule

>>> rtl/tfsc_ratio.sv
module tfsc_ratio (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfsc_pkg::ratio_req_t req,
    output tfsc_pkg::ratio_rsp_t rsp
);
    import tfsc_pkg::*;

    // Computes ceil(tri(num_n) * span / tri(den_n)) with a bit-serial
    // multiply followed by a bit-serial restoring divide.
    ratio_phase_t       phase_reg, phase_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [TRI_W-1:0]   mult_reg, mult_next;
    logic [TRI_W-1:0]   den_reg, den_next;
    logic [SPEED_W-1:0] span_reg, span_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [TRI_W-1:0]   rem_reg, rem_next;
    logic [SPEED_W-1:0] quot_reg, quot_next;
    logic [PROD_W:0]    biased;
    logic [TRI_W:0]     rem_sh;
    logic [TRI_W:0]     rem_diff;
    logic               ge;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            RP_IDLE: if (req.start) phase_next = RP_MUL;
            RP_MUL:  if (cnt_reg == 4'd0) phase_next = RP_BIAS;
            RP_BIAS: phase_next = RP_DIV;
            RP_DIV:  if (cnt_reg == 4'd0) phase_next = RP_DONE;
            RP_DONE: phase_next = RP_IDLE;
            default: phase_next = RP_IDLE;
        endcase
    end

    always_comb
    begin
        biased   = {1'b0, prod_reg} + (PROD_W+1)'(den_reg) - (PROD_W+1)'(1);
        rem_sh   = {rem_reg, prod_reg[SPEED_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};

        cnt_next  = cnt_reg;
        mult_next = mult_reg;
        den_next  = den_reg;
        span_next = span_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        unique case (phase_reg)
            RP_IDLE:
            begin
                if (req.start)
                begin
                    mult_next = tri7(req.num_n);
                    den_next  = tri7(req.den_n);
                    span_next = req.span;
                    prod_next = '0;
                    cnt_next  = 4'(TRI_W - 1);
                end
            end
            RP_MUL:
            begin
                prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                          + (mult_reg[TRI_W-1] ? PROD_W'(span_reg) : '0);
                mult_next = {mult_reg[TRI_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 4'd1;
            end
            RP_BIAS:
            begin
                // The quotient never exceeds the span, so the upper part of
                // the biased product is already below the divisor.
                rem_next  = biased[PROD_W-1:SPEED_W];
                prod_next = {TRI_W'(0), biased[SPEED_W-1:0]};
                quot_next = '0;
                cnt_next  = 4'(SPEED_W - 1);
            end
            RP_DIV:
            begin
                rem_next  = ge ? rem_diff[TRI_W-1:0] : rem_sh[TRI_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                quot_next = {quot_reg[SPEED_W-2:0], ge};
                cnt_next  = cnt_reg - 4'd1;
            end
            RP_DONE:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg <= mult_next;
        den_reg  <= den_next;
        span_reg <= span_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = (phase_reg == RP_DONE);
    assign rsp.quot = quot_reg;

endmodule

>>> rtl/thermal_fan_speed_controller.sv
// Thermal fan speed controller. Sensor words carry a reading in millidegrees
// (tdata bits 16:0) and tlast marks the last reading of a poll. A reading that
// does not end a poll only updates the running maximum, so such words can
// stream back to back. The word that ends a poll runs through a bit-serial
// divide by 1000, a decision state, and, when the temperature sits on one of
// the ramp curves, a bit-serial multiply and restoring divide, then a state
// that loads the output register. The sensor input opens again only once the
// controller is back in idle; a speed word still waiting in the output
// register stretches the load state until the receiver takes it. The first
// valid poll only records the temperature and drives speed_floor. A speed
// word is sent only when the fan speed changes; a poll taken while the
// thresholds or speeds are out of order is dropped. Configuration registers
// are written through the cfg channel, which is always ready, and must only
// be written while no poll is in flight.
module thermal_fan_speed_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sensor stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tfsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [16:0] reading_milli, rest zero
    input  logic                                s_axis_tlast,  // poll_end
    // Speed stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tfsc_pkg::SPEED_W-1:0]        m_axis_tdata,  // [15:0] new_speed
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfsc_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import tfsc_pkg::*;

    ctrl_state_t state_reg, state_next;

    // Configuration registers.
    logic [DEG_W-1:0]   low_reg, ramp_reg, full_reg;
    logic [SPEED_W-1:0] floor_reg, ceil_reg;

    // Controller state.
    logic [READING_W-1:0] peak_reg, peak_next;
    logic [DEG_W-1:0]     t_reg, t_next;
    logic [DEG_W-1:0]     last_deg_reg, last_deg_next;
    logic                 primed_reg, primed_next;
    logic [SPEED_W-1:0]   cur_reg, cur_next;
    logic [SPEED_W-1:0]   spd_reg, spd_next;
    logic                 rise_reg, rise_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SPEED_W-1:0]   m_data_reg, m_data_next;

    deg_req_t   deg_req;
    deg_rsp_t   deg_rsp;
    ratio_req_t ratio_req;
    ratio_rsp_t ratio_rsp;

    logic                 accept;
    logic [READING_W-1:0] reading;
    logic [READING_W-1:0] peak_max;
    logic                 invalid;
    logic                 rise;
    logic                 fall;
    logic [SPEED_W-1:0]   base_speed;
    logic [SPEED_W-1:0]   cand;
    logic                 load;

    tfsc_deg u_deg (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (deg_req),
        .rsp   (deg_rsp)
    );

    tfsc_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ratio_req),
        .rsp   (ratio_rsp)
    );

    assign cfg_ready = 1'b1;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign reading   = s_axis_tdata[READING_W-1:0];
    assign peak_max  = (reading > peak_reg) ? reading : peak_reg;

    // Decision terms on the poll temperature.
    always_comb
    begin
        invalid = (low_reg > ramp_reg) || (ramp_reg > full_reg) || (floor_reg > ceil_reg);
        rise    = (t_reg > last_deg_reg) && (t_reg > ramp_reg) && (t_reg < full_reg);
        fall    = (t_reg < last_deg_reg) && (t_reg > low_reg) && (t_reg < full_reg);
        base_speed = cur_reg;
        if (t_reg >= full_reg)
        begin
            base_speed = ceil_reg;
        end
        if (t_reg <= low_reg)
        begin
            base_speed = floor_reg;
        end
        // The ramp quotient never exceeds the span, so neither form wraps.
        cand = rise_reg ? (floor_reg + ratio_rsp.quot) : (ceil_reg - ratio_rsp.quot);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tlast)
                begin
                    state_next = ST_DEG;
                end
            end
            ST_DEG:
            begin
                if (deg_rsp.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (invalid)
                begin
                    state_next = ST_IDLE;
                end
                else if (primed_reg && (rise || fall))
                begin
                    state_next = ST_RATIO;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RATIO:
            begin
                if (ratio_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if ((spd_reg == cur_reg) || load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_axis_tready     = (state_reg == ST_IDLE);
        deg_req.start     = (state_reg == ST_IDLE) && accept && s_axis_tlast;
        deg_req.dividend  = peak_max;
        ratio_req.start   = (state_reg == ST_DECIDE) && !invalid && primed_reg
                          && (rise || fall);
        ratio_req.num_n   = rise ? (t_reg - ramp_reg) : (full_reg - t_reg);
        ratio_req.den_n   = rise ? (full_reg - ramp_reg) : (full_reg - low_reg);
        ratio_req.span    = ceil_reg - floor_reg;
        load              = (state_reg == ST_EMIT) && (spd_reg != cur_reg)
                          && (!m_valid_reg || m_axis_tready);
    end

    // Datapath next values.
    always_comb
    begin
        peak_next     = peak_reg;
        t_next        = t_reg;
        last_deg_next = last_deg_reg;
        primed_next   = primed_reg;
        cur_next      = cur_reg;
        spd_next      = spd_reg;
        rise_next     = rise_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;

        if (accept)
        begin
            peak_next = s_axis_tlast ? '0 : peak_max;
        end
        if ((state_reg == ST_DEG) && deg_rsp.done)
        begin
            t_next = deg_rsp.degrees;
        end
        if ((state_reg == ST_DECIDE) && !invalid)
        begin
            last_deg_next = t_reg;
            primed_next   = 1'b1;
            rise_next     = rise;
            spd_next      = primed_reg ? base_speed : floor_reg;
        end
        if ((state_reg == ST_RATIO) && ratio_rsp.done)
        begin
            if (rise_reg)
            begin
                spd_next = (cand > spd_reg) ? cand : spd_reg;
            end
            else
            begin
                spd_next = (cand < spd_reg) ? cand : spd_reg;
            end
        end
        if (load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = spd_reg;
            cur_next     = spd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            low_reg      <= RST_LOW_THRESHOLD;
            ramp_reg     <= RST_RAMP_THRESHOLD;
            full_reg     <= RST_FULL_THRESHOLD;
            floor_reg    <= RST_SPEED_FLOOR;
            ceil_reg     <= RST_SPEED_CEILING;
            peak_reg     <= '0;
            last_deg_reg <= '0;
            primed_reg   <= 1'b0;
            cur_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            peak_reg     <= peak_next;
            last_deg_reg <= last_deg_next;
            primed_reg   <= primed_next;
            cur_reg      <= cur_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LOW_THRESHOLD:  low_reg   <= cfg_data[DEG_W-1:0];
                    REG_RAMP_THRESHOLD: ramp_reg  <= cfg_data[DEG_W-1:0];
                    REG_FULL_THRESHOLD: full_reg  <= cfg_data[DEG_W-1:0];
                    REG_SPEED_FLOOR:    floor_reg <= cfg_data;
                    REG_SPEED_CEILING:  ceil_reg  <= cfg_data;
                    default:            low_reg   <= low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        spd_reg    <= spd_next;
        rise_reg   <= rise_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A speed word is only ever sent after a valid poll has primed the block.
    a_emit_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> primed_reg)
        else $error("speed word sent before the first valid poll");

    // Loading the output register publishes the pending speed as the new current one.
    a_load_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (m_axis_tvalid && (m_axis_tdata == $past(spd_reg))
                  && (cur_reg == $past(spd_reg))))
        else $error("output register did not take the new speed");

    // The end of a poll always clears the running maximum.
    a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (peak_reg == '0))
        else $error("running maximum not cleared at end of poll");

    // The serial units only answer while the controller waits for them.
    a_ratio_in_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        ratio_rsp.done |-> (state_reg == ST_RATIO))
        else $error("ramp unit finished outside the ramp state");

    a_deg_in_deg: assert property (@(posedge clk) disable iff (!rst_n)
        deg_rsp.done |-> (state_reg == ST_DEG))
        else $error("degree divider finished outside the divide state");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tfsc_pkg::*;

    // Clock period is 8 ns.
    localparam int unsigned CLK_HALF = 4;

    // Watchdog on the whole run. The slowest correct run has every word a poll
    // end that takes the ramp path, a long sender gap, and a long receiver stall
    // per speed word.
    localparam int unsigned CYCLE_LIMIT = 1_200_000;

    // A poll can be dropped or leave the speed unchanged. It sends no word,
    // but it still occupies the block until the controller is idle again. Wait this
    // long before a register write and before the end of the run.
    localparam int unsigned SETTLE_CYCLES = 80;

    localparam int unsigned RANDOM_WORDS = 1000;
    localparam int unsigned READING_MAX  = (1 << READING_W) - 1;
    localparam int          HOTTEST_DEG  = READING_MAX / MILLI_PER_DEG;
    localparam int unsigned REPORT_CAP   = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [16:0] reading_milli, rest zero
    logic                   s_axis_tlast;   // poll_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [SPEED_W-1:0]     m_axis_tdata;   // [15:0] new_speed
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_data;

    thermal_fan_speed_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // The predictor keeps its own copy of the registers and of the
    // controller state. It is updated on every accepted word.
    logic [DEG_W-1:0]     thr_low;
    logic [DEG_W-1:0]     thr_ramp;
    logic [DEG_W-1:0]     thr_full;
    logic [SPEED_W-1:0]   rpm_floor;
    logic [SPEED_W-1:0]   rpm_ceil;
    logic [READING_W-1:0] peak_milli;
    logic [DEG_W-1:0]     prev_deg;
    logic [SPEED_W-1:0]   fan_rpm;
    bit                   primed_seen;

    // Speed words that the block still owes, oldest first.
    logic [SPEED_W-1:0]   speed_expected[$];

    int unsigned error_count = 0;
    int unsigned cycles_run  = 0;
    int unsigned words_sent  = 0;

    // Traffic shaping. A calm side never idles. hold_off makes the receiver
    // refuse speed words for that many cycles; the receiver counts it down.
    bit          tx_calm  = 1'b0;
    bit          rx_calm  = 1'b0;
    int unsigned hold_off = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Runs out of time only if the block hangs or loses a speed word.
    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("** thermal_fan_speed_controller: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_model();
        thr_low     = RST_LOW_THRESHOLD;
        thr_ramp    = RST_RAMP_THRESHOLD;
        thr_full    = RST_FULL_THRESHOLD;
        rpm_floor   = RST_SPEED_FLOOR;
        rpm_ceil    = RST_SPEED_CEILING;
        peak_milli  = '0;
        prev_deg    = '0;
        fan_rpm     = '0;
        primed_seen = 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DAT_W-1:0] value);
        case (idx)
            REG_LOW_THRESHOLD:  thr_low   = value[DEG_W-1:0];
            REG_RAMP_THRESHOLD: thr_ramp  = value[DEG_W-1:0];
            REG_FULL_THRESHOLD: thr_full  = value[DEG_W-1:0];
            REG_SPEED_FLOOR:    rpm_floor = value[SPEED_W-1:0];
            REG_SPEED_CEILING:  rpm_ceil  = value[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    // Sum 1 + 2 + ... + n, the step curve used on both ramps.
    function automatic longint unsigned stair_sum(input longint unsigned n);
        return n * (n + 1) / 2;
    endfunction

    function automatic longint unsigned div_round_up(input longint unsigned num,
                                                     input longint unsigned den);
        return (num + den - 1) / den;
    endfunction

    // Speed after a poll at t degrees, once the controller has been primed.
    function automatic logic [SPEED_W-1:0] poll_speed_for(input int unsigned t);
        int unsigned       spd;
        int unsigned       span;
        int unsigned       cand;
        longint unsigned   num;
        longint unsigned   den;
        spd  = fan_rpm;
        span = rpm_ceil - rpm_floor;
        if (t >= thr_full && fan_rpm != rpm_ceil)
            spd = rpm_ceil;
        if (t <= thr_low)
            spd = rpm_floor;
        // Rising through the ramp band: the speed only goes up.
        if (t > prev_deg && t > thr_ramp && t < thr_full)
        begin
            num  = stair_sum(t - thr_ramp) * span;
            den  = stair_sum(thr_full - thr_ramp);
            cand = rpm_floor + 32'(div_round_up(num, den));
            if (cand > spd)
                spd = cand;
        end
        // Falling between low and full: the speed only goes down.
        if (t < prev_deg && t > thr_low && t < thr_full)
        begin
            num  = stair_sum(thr_full - t) * span;
            den  = stair_sum(thr_full - thr_low);
            cand = rpm_ceil - 32'(div_round_up(num, den));
            if (cand < spd)
                spd = cand;
        end
        return spd[SPEED_W-1:0];
    endfunction

    function automatic void absorb_reading(input logic [READING_W-1:0] milli,
                                           input logic last);
        int unsigned        t;
        logic [SPEED_W-1:0] spd;
        if (milli > peak_milli)
            peak_milli = milli;
        if (!last)
            return;
        t = peak_milli / MILLI_PER_DEG;
        if (t > DEG_MAX)
            t = DEG_MAX;
        peak_milli = '0;
        // Out-of-order settings drop the whole poll.
        if (thr_low > thr_ramp || thr_ramp > thr_full || rpm_floor > rpm_ceil)
            return;
        if (!primed_seen)
        begin
            primed_seen = 1'b1;
            spd = rpm_floor;
        end
        else
            spd = poll_speed_for(t);
        prev_deg = t[DEG_W-1:0];
        if (spd == fan_rpm)
            return;
        fan_rpm = spd;
        speed_expected.push_back(spd);
    endfunction

    // ------------------------------------------------------------------
    // Speed word receiver and checker
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [SPEED_W-1:0] got,
                                   input logic [SPEED_W-1:0] want);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("ERROR at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    endtask

    // tready changes on the falling edge. A requested hold-off takes
    // priority over the random stalls.
    initial
    begin
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off != 0)
            begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [SPEED_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (speed_expected.size() == 0)
                    report_mismatch("speed word with none pending", m_axis_tdata, '0);
                else
                begin
                    want = speed_expected.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("new_speed differs", m_axis_tdata, want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sensor and configuration drivers
    // ------------------------------------------------------------------

    // Offers one reading, waits for it to be taken, then feeds the predictor.
    // tvalid stays high afterward, so the next call must follow at once,
    // or quiet_sensor must be called before any other wait.
    task automatic send_word(input logic [READING_W-1:0] milli, input logic last);
        int unsigned gap;
        gap = tx_calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - READING_W){1'b0}}, milli};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_reading(milli, last);
        words_sent++;
    endtask

    task automatic quiet_sensor();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // One poll whose hottest reading lands in the given whole degree. The
    // other readings are no hotter and sit at random places in the poll.
    task automatic send_poll(input int heat);
        int unsigned n;
        int unsigned peak;
        int unsigned slot;
        int unsigned roll;
        if (heat < 0)
            heat = 0;
        if (heat > HOTTEST_DEG)
            heat = HOTTEST_DEG;
        peak = heat * MILLI_PER_DEG + $urandom_range(0, MILLI_PER_DEG - 1);
        if (peak > READING_MAX)
            peak = READING_MAX;
        roll = $urandom_range(0, 19);
        n    = (roll < 12) ? 1 : (roll < 17) ? 2 : $urandom_range(3, 5);
        slot = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
            send_word(READING_W'((i == slot) ? peak : $urandom_range(0, peak)),
                      i == n - 1);
    endtask

    task automatic wait_drained();
        while (speed_expected.size() != 0)
            @(posedge clk);
    endtask

    // The block is idle once every speed word has arrived and any poll
    // that sends no word has had time to finish.
    task automatic wait_idle();
        quiet_sensor();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Threshold registers are 7 bits wide. When junk is set, the unused
    // upper data bits are filled at random, and the block must ignore them.
    task automatic load_settings(input int lo, input int ramp, input int full,
                                 input int floor_rpm, input int ceil_rpm, input bit junk);
        logic [CFG_DAT_W-1:0] pad;
        pad = junk ? (CFG_DAT_W'($urandom) & ~CFG_DAT_W'(DEG_MAX)) : '0;
        write_reg(REG_LOW_THRESHOLD,  CFG_DAT_W'(lo)   | pad);
        write_reg(REG_RAMP_THRESHOLD, CFG_DAT_W'(ramp) | pad);
        write_reg(REG_FULL_THRESHOLD, CFG_DAT_W'(full) | pad);
        write_reg(REG_SPEED_FLOOR,    CFG_DAT_W'(floor_rpm));
        write_reg(REG_SPEED_CEILING,  CFG_DAT_W'(ceil_rpm));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked polls under the reset settings. These cover the first poll,
    // the saturating reading, both forced speeds, both ramps, and polls that
    // leave the speed alone. Before that, a poll taken while the speeds are out
    // of order must not prime the controller.
    task automatic test_directed_polls();
        write_reg(REG_SPEED_FLOOR, CFG_DAT_W'(7000));
        send_word(17'd45_000, 1'b1);
        wait_idle();
        write_reg(REG_SPEED_FLOOR, RST_SPEED_FLOOR);

        send_word(17'd31_000, 1'b0);    // first poll, peak in the middle
        send_word(17'd64_999, 1'b0);
        send_word(17'd12_000, 1'b1);
        send_word(17'd131_071, 1'b1);   // 131 degrees saturates, full speed
        send_word(17'd86_000, 1'b1);    // at full and already at ceiling
        send_word(17'd75_400, 1'b1);    // falling, speed steps down
        send_word(17'd80_000, 1'b1);    // rising, curve below current speed
        send_word(17'd88_500, 1'b1);
        send_word(17'd0, 1'b0);
        send_word(17'd67_999, 1'b0);
        send_word(17'd1, 1'b1);         // falls back to 67 degrees
        send_word(17'd63_999, 1'b1);    // at low threshold, minimum speed
        send_word(17'd0, 1'b1);         // stays at minimum
        send_word(17'd70_000, 1'b1);    // rising into the ramp
        send_word(17'd66_999, 1'b1);    // small fall, no lower
        send_word(17'd85_999, 1'b1);    // top of the ramp
        send_word(17'd127_999, 1'b1);
    endtask

    // Sweeps the temperature up and down under one setting.
    task automatic sweep_settings(input int lo, input int ramp, input int full,
                                  input int floor_rpm, input int ceil_rpm);
        int marks[14];
        wait_idle();
        load_settings(lo, ramp, full, floor_rpm, ceil_rpm, 1'b0);
        marks = '{0, lo, lo + 1, ramp, ramp + 1, (ramp + full) / 2, full - 1, full,
                  DEG_MAX, HOTTEST_DEG, full - 1, (lo + full) / 2, lo + 1, lo};
        foreach (marks[i])
            send_poll(marks[i]);
    endtask

    task automatic test_register_extremes();
        int idx;
        // Writes to indexes past the last register must change nothing.
        wait_idle();
        for (idx = int'(REG_SPEED_CEILING) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), '1);
        sweep_settings(0, 0, 127, 0, 65535);
        sweep_settings(127, 127, 127, 65535, 65535);
        sweep_settings(0, 1, 2, 0, 65535);
        sweep_settings(50, 50, 50, 1000, 1000);
        sweep_settings(10, 90, 100, 0, 65535);
        sweep_settings(70, 60, 90, 500, 6500);      // thresholds out of order
        sweep_settings(20, 30, 40, 7000, 6000);     // speeds out of order
        sweep_settings(int'(RST_LOW_THRESHOLD), int'(RST_RAMP_THRESHOLD),
                       int'(RST_FULL_THRESHOLD), int'(RST_SPEED_FLOOR),
                       int'(RST_SPEED_CEILING));
    endtask

    // The receiver holds off for a long stretch while hot and cold polls keep
    // coming. Every poll changes the speed, so the block fills up and has to
    // stall its sensor input.
    task automatic test_output_stall();
        quiet_sensor();
        wait_drained();
        tx_calm  = 1'b1;
        hold_off = 600;
        for (int i = 0; i < 24; i++)
            send_poll((i % 2 == 0) ? HOTTEST_DEG : 0);
        tx_calm = 1'b0;
    endtask

    // The sender pauses partway until every pending speed word has come out.
    task automatic test_drain_pause();
        for (int i = 0; i < 15; i++)
            send_poll($urandom_range(55, 95));
        quiet_sensor();
        wait_drained();
        for (int i = 0; i < 15; i++)
            send_poll($urandom_range(55, 95));
    endtask

    task automatic load_random_settings();
        int a;
        int b;
        int c;
        int f;
        int g;
        int tmp;
        a = $urandom_range(0, 127);
        b = $urandom_range(0, 127);
        c = $urandom_range(0, 127);
        // Narrow bands now and then, so the ramps get steep.
        if ($urandom_range(0, 3) == 0)
        begin
            b = a + $urandom_range(0, 4);
            c = b + $urandom_range(0, 4);
            if (c > 127)
                c = 127;
            if (b > c)
                b = c;
        end
        if (a > b) begin tmp = a; a = b; b = tmp; end
        if (b > c) begin tmp = b; b = c; c = tmp; end
        if (a > b) begin tmp = a; a = b; b = tmp; end
        if ($urandom_range(0, 5) == 0)
            a = 0;
        if ($urandom_range(0, 5) == 0)
            c = 127;
        f = $urandom_range(0, 65535);
        g = $urandom_range(0, 65535);
        if (f > g) begin tmp = f; f = g; g = tmp; end
        load_settings(a, b, c, f, g, 1'($urandom_range(0, 1)));
    endtask

    // Phases of random polls that follow a wandering temperature around the
    // current thresholds, with some stray single words mixed in. Between
    // phases the block is drained and the settings stay or change in one of three
    // ways: a complete new set, a single register, or a random set that may be out of order.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned phase_len;
        int unsigned phase_start;
        int unsigned roll;
        int          heat;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal)
        begin
            wait_idle();
            roll = $urandom_range(0, 9);
            if (roll < 6)
                load_random_settings();
            else if (roll < 8)
                write_reg(CFG_IDX_W'($urandom_range(0, int'(REG_SPEED_CEILING))),
                          CFG_DAT_W'($urandom));
            else if (roll == 8)
                load_settings($urandom_range(0, 127), $urandom_range(0, 127),
                              $urandom_range(0, 127), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), 1'b1);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            heat = $urandom_range(0, 10) + int'(thr_low) - 5;
            if (thr_full > thr_low)
                heat = int'(thr_low) - 5 + $urandom_range(0, thr_full - thr_low + 10);
            phase_len   = $urandom_range(20, 90);
            phase_start = words_sent;
            while (words_sent - phase_start < phase_len && words_sent < goal)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    send_word(READING_W'($urandom_range(0, READING_MAX)),
                              1'($urandom_range(0, 1)));
                else
                begin
                    if (roll == 1)
                        heat = $urandom_range(0, HOTTEST_DEG);
                    else
                        heat = heat + int'($urandom_range(0, 14)) - 7;
                    if (heat < 0)
                        heat = 0;
                    if (heat > HOTTEST_DEG)
                        heat = HOTTEST_DEG;
                    send_poll(heat);
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        clear_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_polls();
        test_register_extremes();
        test_output_stall();
        test_drain_pause();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("** thermal_fan_speed_controller: PASSED **");
        else
            $display("** thermal_fan_speed_controller: FAILED **");
        $finish;
    end

endmodule
